// ===== design/linear_blend_vertex_skinning_unit_assert.svh =====
// Assertion macros for the linear blend skinning unit.
// Used by the top level; empty when SYNTHESIS is defined.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_UNIT_ASSERT_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LBVS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lbvs assertion failed");
`define LBVS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("lbvs assertion failed");
`else
`define LBVS_ASSERT(lbl, clk, rstn, prop)
`define LBVS_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== design/lbvs_pkg.sv =====
// Shared constants and saturation helpers for the skinning unit.
// No dependencies.
package lbvs_pkg;
  localparam int unsigned MAX_JOINTS_DEF = 64;
  localparam int unsigned ROW_ELEMS      = 12;
  localparam int unsigned MUL_W          = 33;
  localparam int unsigned ACC_W          = 48;
  localparam int unsigned SUM_W          = 51;
  localparam logic [16:0] ONE_Q16        = 17'h10000;
  localparam logic        OP_WRITE       = 1'b0;
  localparam logic        OP_WEIGHT      = 1'b1;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
    logic signed [ACC_W-1:0] r;
    if (x[SUM_W-1:ACC_W-1] == '0 || x[SUM_W-1:ACC_W-1] == '1) begin
      r = x[ACC_W-1:0];
    end else if (x[SUM_W-1]) begin
      r = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_out(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if (x[ACC_W-1:31] == '0 || x[ACC_W-1:31] == '1) begin
      r = x[31:0];
    end else if (x[ACC_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction
endpackage

// ===== design/lbvs_req_if.sv =====
// Request channel of the skinning unit: valid, ready and request fields.
// Depends on nothing.
interface lbvs_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [5:0]         joint;
  logic [3:0]         element_index;
  logic signed [31:0] element_value;
  logic signed [31:0] bind_pos_x;
  logic signed [31:0] bind_pos_y;
  logic signed [31:0] bind_pos_z;
  logic signed [31:0] bind_nrm_x;
  logic signed [31:0] bind_nrm_y;
  logic signed [31:0] bind_nrm_z;
  logic [16:0]        bias;
  logic               last_weight;

  modport source (output valid, opcode, joint, element_index, element_value, bind_pos_x,
                  bind_pos_y, bind_pos_z, bind_nrm_x, bind_nrm_y, bind_nrm_z, bias,
                  last_weight, input ready);
  modport sink (input valid, opcode, joint, element_index, element_value, bind_pos_x,
                bind_pos_y, bind_pos_z, bind_nrm_x, bind_nrm_y, bind_nrm_z, bias,
                last_weight, output ready);
endinterface

// ===== design/lbvs_rsp_if.sv =====
// Response channel of the skinning unit: skinned position and normal.
// Depends on nothing.
interface lbvs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] skin_pos_x;
  logic signed [31:0] skin_pos_y;
  logic signed [31:0] skin_pos_z;
  logic signed [31:0] skin_nrm_x;
  logic signed [31:0] skin_nrm_y;
  logic signed [31:0] skin_nrm_z;

  modport source (output valid, skin_pos_x, skin_pos_y, skin_pos_z, skin_nrm_x,
                  skin_nrm_y, skin_nrm_z, input ready);
  modport sink (input valid, skin_pos_x, skin_pos_y, skin_pos_z, skin_nrm_x,
                skin_nrm_y, skin_nrm_z, output ready);
endinterface

// ===== design/lbvs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbvs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

// ===== design/lbvs_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on lbvs_pkg.
module lbvs_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [lbvs_pkg::MUL_W-1:0]    a_i,
  input  logic signed [lbvs_pkg::MUL_W-1:0]    b_i,
  output logic signed [2*lbvs_pkg::MUL_W-1:0]  p_o
);
  import lbvs_pkg::*;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= a_i * b_i;
    end
  end
endmodule

// ===== design/linear_blend_vertex_skinning_unit.sv =====
// Linear blend skinning unit: a palette write goes to the RAM and the unit stays idle; a
// weight request for a joint in range runs 3 matrix rows x (position pass of 4 palette
// reads, normal pass of 3), all products going through one shared 33x33 multiplier; the
// next request is taken only back in S_IDLE; after the last weight the response register
// is loaded in S_EMIT, which holds while a previous response still waits. Reset clears
// control state and accumulators, not the palette. Depends on lbvs_pkg, lbvs_ram, lbvs_mul.
module linear_blend_vertex_skinning_unit #(
  parameter int unsigned MaxJoints = lbvs_pkg::MAX_JOINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbvs_req_if.sink    req_i,
  lbvs_rsp_if.source  rsp_o
);
  import lbvs_pkg::*;
  `include "linear_blend_vertex_skinning_unit_assert.svh"

  localparam int unsigned Depth = MaxJoints * ROW_ELEMS;
  localparam int unsigned AW    = $clog2(Depth);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_ADD, S_SAT, S_BHI, S_BLO, S_ACC, S_EMIT
  } state_e;

  state_e                   state_q, state_d;
  logic [5:0]               joint_q, joint_d;
  logic [16:0]              bias_q, bias_d;
  logic                     last_q, last_d;
  logic signed [31:0]       vec_q [6];
  logic [1:0]               row_q, row_d, col_q, col_d;
  logic                     nrm_q, nrm_d;
  logic signed [SUM_W-1:0]  t_q, t_d;
  logic signed [ACC_W-1:0]  ts_q, ts_d;
  logic signed [48:0]       hi_q, hi_d;
  logic signed [ACC_W-1:0]  pacc_q [3];
  logic signed [ACC_W-1:0]  nacc_q [3];
  logic signed [ACC_W-1:0]  acc_new;
  logic                     out_valid_q, out_valid_d;
  logic signed [31:0]       out_q [6];

  logic                     accept, joint_ok, we, re, mul_en;
  logic [11:0]              wide_waddr, wide_raddr;
  logic [31:0]              rdata;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic [2:0]               vidx;
  logic signed [ACC_W-1:0]  acc_cur;
  logic signed [SUM_W-1:0]  acc_sum;

  assign accept   = req_i.valid && req_i.ready;
  assign joint_ok = {3'b0, req_i.joint} < 9'(MaxJoints);
  assign we       = accept && req_i.opcode == OP_WRITE && joint_ok &&
                    req_i.element_index < 4'(ROW_ELEMS);
  assign wide_waddr = 12'({req_i.joint, 3'b000}) + 12'({req_i.joint, 2'b00}) +
                      12'(req_i.element_index);
  assign wide_raddr = 12'({joint_q, 3'b000}) + 12'({joint_q, 2'b00}) +
                      12'({row_q, col_q});
  assign re = state_q == S_RD;

  lbvs_ram #(.Width(32), .Depth(Depth)) u_palette (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(wide_waddr)),
    .wdata_i (req_i.element_value),
    .re_i    (re),
    .raddr_i (AW'(wide_raddr)),
    .rdata_o (rdata)
  );

  assign vidx = {1'b0, col_q} + (nrm_q ? 3'd3 : 3'd0);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = {{(MUL_W-32){rdata[31]}}, rdata};
    mul_b  = {vec_q[vidx][31], vec_q[vidx]};
    case (state_q)
      S_MUL: mul_en = col_q != 2'd3;
      S_BHI: begin
        mul_en = 1'b1;
        mul_a  = {ts_q[ACC_W-1], ts_q[ACC_W-1:16]};
        mul_b  = {16'b0, bias_q};
      end
      S_BLO: begin
        mul_en = 1'b1;
        mul_a  = {17'b0, ts_q[15:0]};
        mul_b  = {16'b0, bias_q};
      end
      default: mul_en = 1'b0;
    endcase
  end

  lbvs_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign acc_cur = nrm_q ? nacc_q[row_q] : pacc_q[row_q];
  assign acc_sum = SUM_W'(acc_cur) + SUM_W'(hi_q) + SUM_W'({1'b0, prod[32:16]});
  assign acc_new = sat_acc(acc_sum);

  always_comb begin
    state_d     = state_q;
    joint_d     = joint_q;
    bias_d      = bias_q;
    last_d      = last_q;
    row_d       = row_q;
    col_d       = col_q;
    nrm_d       = nrm_q;
    t_d         = t_q;
    ts_d        = ts_q;
    hi_d        = hi_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    case (state_q)
      S_IDLE: begin
        if (accept && req_i.opcode == OP_WEIGHT) begin
          joint_d = req_i.joint;
          bias_d  = (req_i.bias > ONE_Q16) ? ONE_Q16 : req_i.bias;
          last_d  = req_i.last_weight;
          row_d   = 2'd0;
          col_d   = 2'd0;
          nrm_d   = 1'b0;
          t_d     = '0;
          if (joint_ok) begin
            state_d = S_RD;
          end else if (req_i.last_weight) begin
            state_d = S_EMIT;
          end
        end
      end
      S_RD: state_d = S_MUL;
      S_MUL: begin
        if (col_q == 2'd3) begin
          t_d     = t_q + SUM_W'($signed(rdata));
          state_d = S_SAT;
        end else begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        t_d = t_q + SUM_W'($signed(prod[63:16]));
        if (col_q == 2'd2 && nrm_q) begin
          state_d = S_SAT;
        end else begin
          col_d   = col_q + 2'd1;
          state_d = S_RD;
        end
      end
      S_SAT: begin
        ts_d    = sat_acc(t_q);
        state_d = S_BHI;
      end
      S_BHI: state_d = S_BLO;
      S_BLO: begin
        hi_d    = prod[48:0];
        state_d = S_ACC;
      end
      S_ACC: begin
        t_d   = '0;
        col_d = 2'd0;
        if (!nrm_q) begin
          nrm_d   = 1'b1;
          state_d = S_RD;
        end else begin
          nrm_d = 1'b0;
          if (row_q == 2'd2) begin
            row_d   = 2'd0;
            state_d = last_q ? S_EMIT : S_IDLE;
          end else begin
            row_d   = row_q + 2'd1;
            state_d = S_RD;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      row_q       <= 2'd0;
      col_q       <= 2'd0;
      nrm_q       <= 1'b0;
      last_q      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pacc_q[i] <= '0;
        nacc_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      row_q       <= row_d;
      col_q       <= col_d;
      nrm_q       <= nrm_d;
      last_q      <= last_d;
      joint_q     <= joint_d;
      bias_q      <= bias_d;
      t_q         <= t_d;
      ts_q        <= ts_d;
      hi_q        <= hi_d;
      if (state_q == S_IDLE && accept && req_i.opcode == OP_WEIGHT) begin
        vec_q[0] <= req_i.bind_pos_x;
        vec_q[1] <= req_i.bind_pos_y;
        vec_q[2] <= req_i.bind_pos_z;
        vec_q[3] <= req_i.bind_nrm_x;
        vec_q[4] <= req_i.bind_nrm_y;
        vec_q[5] <= req_i.bind_nrm_z;
      end
      if (state_q == S_ACC) begin
        if (nrm_q) begin
          nacc_q[row_q] <= acc_new;
        end else begin
          pacc_q[row_q] <= acc_new;
        end
      end
      if (state_q == S_EMIT && (!out_valid_q || rsp_o.ready)) begin
        for (int i = 0; i < 3; i++) begin
          out_q[i]     <= sat_out(pacc_q[i]);
          out_q[3 + i] <= sat_out(nacc_q[i]);
          pacc_q[i]    <= '0;
          nacc_q[i]    <= '0;
        end
      end
    end
  end

  assign req_i.ready       = state_q == S_IDLE;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.skin_pos_x  = out_q[0];
  assign rsp_o.skin_pos_y  = out_q[1];
  assign rsp_o.skin_pos_z  = out_q[2];
  assign rsp_o.skin_nrm_x  = out_q[3];
  assign rsp_o.skin_nrm_y  = out_q[4];
  assign rsp_o.skin_nrm_z  = out_q[5];

  `LBVS_ASSERT(a_rd_joint_ok, clk_i, rst_ni, (state_q == S_RD) |-> (9'(joint_q) < 9'(MaxJoints)))
  `LBVS_ASSERT_NEXT(a_emit_clears, clk_i, rst_ni, state_q == S_EMIT && state_d == S_IDLE, pacc_q[0] == '0 && nacc_q[2] == '0 && out_valid_q)
  `LBVS_ASSERT_NEXT(a_weight_starts, clk_i, rst_ni, accept && req_i.opcode == OP_WEIGHT && joint_ok, state_q == S_RD)
endmodule

// ===== verif/lbvs_checker.sv =====
// Checker for the skinning unit: watches the request and response channels,
// predicts each skinned vertex from its weight requests up to the last weight
// and compares field by field. Depends on lbvs_pkg, lbvs_req_if, lbvs_rsp_if.
module lbvs_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  lbvs_req_if.sink   req_i,
  lbvs_rsp_if.sink   rsp_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lbvs_pkg::*;

  localparam logic signed [63:0] AccMax = 64'sh7FFF_FFFF_FFFF;
  localparam logic signed [63:0] AccMin = -64'sh7FFF_FFFF_FFFF - 64'sd1;

  typedef struct packed {
    logic signed [31:0] px, py, pz, nx, ny, nz;
  } vertex_t;

  logic signed [31:0] palette [MAX_JOINTS_DEF*ROW_ELEMS];
  logic signed [63:0] pos_sum [3];
  logic signed [63:0] nrm_sum [3];
  vertex_t            skinned_q [$];

  function automatic logic signed [63:0] clamp(logic signed [63:0] x,
                                               logic signed [63:0] lo,
                                               logic signed [63:0] hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic logic signed [63:0] row_term(int j, int r,
      logic signed [31:0] v0, logic signed [31:0] v1, logic signed [31:0] v2, bit with_w);
    logic signed [63:0] t;
    t = ((64'(palette[j*12+r*4]) * 64'(v0)) >>> 16)
      + ((64'(palette[j*12+r*4+1]) * 64'(v1)) >>> 16)
      + ((64'(palette[j*12+r*4+2]) * 64'(v2)) >>> 16);
    if (with_w) t += 64'(palette[j*12+r*4+3]);
    return clamp(t, AccMin, AccMax);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [63:0] b, t;
    vertex_t exp_v;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        pos_sum[i] = 0;
        nrm_sum[i] = 0;
      end
      fail_count_o <= 0;
      skinned_q.delete();
      pending_o = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        if (req_i.opcode == OP_WRITE) begin
          if (req_i.element_index < ROW_ELEMS)
            palette[req_i.joint*12+req_i.element_index] = req_i.element_value;
        end else begin
          b = (req_i.bias > ONE_Q16) ? 64'sd65536 : 64'(req_i.bias);
          for (int r = 0; r < 3; r++) begin
            t = row_term(req_i.joint, r, req_i.bind_pos_x, req_i.bind_pos_y,
                         req_i.bind_pos_z, 1'b1);
            pos_sum[r] = clamp(pos_sum[r] + ((t * b) >>> 16), AccMin, AccMax);
            t = row_term(req_i.joint, r, req_i.bind_nrm_x, req_i.bind_nrm_y,
                         req_i.bind_nrm_z, 1'b0);
            nrm_sum[r] = clamp(nrm_sum[r] + ((t * b) >>> 16), AccMin, AccMax);
          end
          if (req_i.last_weight) begin
            exp_v.px = 32'(clamp(pos_sum[0], -64'sd2147483648, 64'sd2147483647));
            exp_v.py = 32'(clamp(pos_sum[1], -64'sd2147483648, 64'sd2147483647));
            exp_v.pz = 32'(clamp(pos_sum[2], -64'sd2147483648, 64'sd2147483647));
            exp_v.nx = 32'(clamp(nrm_sum[0], -64'sd2147483648, 64'sd2147483647));
            exp_v.ny = 32'(clamp(nrm_sum[1], -64'sd2147483648, 64'sd2147483647));
            exp_v.nz = 32'(clamp(nrm_sum[2], -64'sd2147483648, 64'sd2147483647));
            skinned_q.insert(skinned_q.size(), exp_v);
            for (int i = 0; i < 3; i++) begin
              pos_sum[i] = 0;
              nrm_sum[i] = 0;
            end
          end
        end
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (skinned_q.size() == 0) begin
          $display("%0t: unexpected vertex %h %h %h %h %h %h", $time,
                   rsp_i.skin_pos_x, rsp_i.skin_pos_y, rsp_i.skin_pos_z,
                   rsp_i.skin_nrm_x, rsp_i.skin_nrm_y, rsp_i.skin_nrm_z);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_v = skinned_q.pop_front();
          if (exp_v != {rsp_i.skin_pos_x, rsp_i.skin_pos_y, rsp_i.skin_pos_z,
                        rsp_i.skin_nrm_x, rsp_i.skin_nrm_y, rsp_i.skin_nrm_z}) begin
            $display("%0t: vertex mismatch expected pos %h %h %h nrm %h %h %h", $time,
                     exp_v.px, exp_v.py, exp_v.pz, exp_v.nx, exp_v.ny, exp_v.nz);
            $display("%0t:                   actual pos %h %h %h nrm %h %h %h", $time,
                     rsp_i.skin_pos_x, rsp_i.skin_pos_y, rsp_i.skin_pos_z,
                     rsp_i.skin_nrm_x, rsp_i.skin_nrm_y, rsp_i.skin_nrm_z);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o = skinned_q.size();
    end
  end
endmodule

// ===== verif/testbench.sv =====
// Top of the skinning unit testbench: clock, reset, palette and weight requests
// with random idling and response stalls, and the verdict.
// Depends on lbvs_pkg, lbvs_req_if, lbvs_rsp_if, lbvs_checker and the unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lbvs_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, cycle_count;
  bit   no_idle;
  bit   written [MAX_JOINTS_DEF];

  lbvs_req_if req_if ();
  lbvs_rsp_if rsp_if ();

  linear_blend_vertex_skinning_unit dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .req_i (req_if.sink), .rsp_o (rsp_if.source)
  );

  lbvs_checker u_checker (
    .clk_i (clk_i), .rst_ni (rst_ni), .req_i (req_if.sink), .rsp_i (rsp_if.sink),
    .fail_count_o (fail_count), .pending_o (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.opcode = OP_WRITE;
    req_if.joint = '0;
    req_if.element_index = '0;
    req_if.element_value = '0;
    req_if.bind_pos_x = '0;
    req_if.bind_pos_y = '0;
    req_if.bind_pos_z = '0;
    req_if.bind_nrm_x = '0;
    req_if.bind_nrm_y = '0;
    req_if.bind_nrm_z = '0;
    req_if.bias = '0;
    req_if.last_weight = 1'b0;
    rsp_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    rsp_if.ready <= no_idle || ($urandom_range(99) >= 34);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3_000_000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end
  initial cycle_count = 0;

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'(signed'($urandom_range(131072)) - 65536);
      3: return 32'(signed'($urandom_range(8388608)) - 4194304);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic op, logic [5:0] j, logic [3:0] ei, logic signed [31:0] ev,
                      logic [16:0] b, logic lw, bit full_range);
    while (!no_idle && $urandom_range(99) < 34) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.opcode <= op;
    req_if.joint <= j;
    req_if.element_index <= ei;
    req_if.element_value <= ev;
    req_if.bind_pos_x <= full_range ? $urandom : rand_value();
    req_if.bind_pos_y <= full_range ? $urandom : rand_value();
    req_if.bind_pos_z <= full_range ? $urandom : rand_value();
    req_if.bind_nrm_x <= full_range ? $urandom : rand_value();
    req_if.bind_nrm_y <= full_range ? $urandom : rand_value();
    req_if.bind_nrm_z <= full_range ? $urandom : rand_value();
    req_if.bias <= b;
    req_if.last_weight <= lw;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic write_bone(logic [5:0] j);
    for (int e = 0; e < ROW_ELEMS; e++) begin
      send(OP_WRITE, j, 4'(e), rand_value(), 17'd0, 1'b0, 1'b0);
    end
    written[j] = 1'b1;
  endtask

  function automatic logic [5:0] pick_joint();
    logic [5:0] j;
    do j = 6'($urandom_range(63)); while (!written[j]);
    return j;
  endfunction

  initial begin
    logic [5:0] j;
    int nw;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_bone(6'd0);
    write_bone(6'd63);
    send(OP_WRITE, 6'd5, 4'd12, 32'sh7FFF_FFFF, 17'd0, 1'b0, 1'b0);
    send(OP_WRITE, 6'd5, 4'd15, 32'sh8000_0000, 17'd0, 1'b0, 1'b0);
    send(OP_WEIGHT, 6'd0, 4'd0, 32'sd0, 17'h10000, 1'b1, 1'b1);
    send(OP_WEIGHT, 6'd63, 4'd0, 32'sd0, 17'h1FFFF, 1'b0, 1'b1);
    send(OP_WEIGHT, 6'd0, 4'd0, 32'sd0, 17'h1FFFF, 1'b1, 1'b1);
    send(OP_WEIGHT, 6'd0, 4'd0, 32'sd0, 17'd0, 1'b1, 1'b0);
    send(OP_WEIGHT, 6'd63, 4'd0, 32'sd0, 17'h08000, 1'b0, 1'b0);
    send(OP_WEIGHT, 6'd0, 4'd0, 32'sd0, 17'h08000, 1'b1, 1'b0);
    send(OP_WEIGHT, 6'd0, 4'd0, 32'sd0, 17'h0FFFF, 1'b1, 1'b1);
    send(OP_WEIGHT, 6'd0, 4'd0, 32'sd0, 17'h00001, 1'b1, 1'b0);
    for (int k = 1; k < 63; k++) write_bone(6'(k));
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    for (int k = 0; k < 480 && k < 2000; k++) begin
      no_idle = (k >= 150 && k < 230);
      if ($urandom_range(19) == 0) begin
        j = pick_joint();
        send(OP_WRITE, j, 4'($urandom_range(15)), rand_value(), 17'd0, 1'b0, 1'b0);
      end else begin
        nw = $urandom_range(1, 4);
        for (int w = 0; w < nw; w++) begin
          j = pick_joint();
          send(OP_WEIGHT, j, 4'($urandom), $urandom, 17'($urandom_range(20) == 0 ?
               $urandom : $urandom_range(65536)), 1'(w == nw - 1), $urandom_range(3) == 0);
        end
      end
    end
    no_idle = 1'b0;
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/lbvs_pkg.sv
design/lbvs_req_if.sv
design/lbvs_rsp_if.sv
design/lbvs_ram.sv
design/lbvs_mul.sv
design/linear_blend_vertex_skinning_unit.sv
verif/lbvs_checker.sv
verif/testbench.sv
